// ===== src/baa_pkg.sv =====
// Package for the beam attenuation and absorption pipeline.
// Beat types, pipeline context type and the exp(-x) coefficient table.
// No dependencies.
`default_nettype none

package baa_pkg;

  localparam int unsigned NUM_ROM   = 12;  // table bits of x, positions 8..19
  localparam int unsigned FRAC_BITS = 8;   // low bits of x handled by the polynomial
  localparam int unsigned LATENCY   = 16;  // front + 13 multiply stages + 2 output stages

  // 1.0 in Q0.32, one bit above the fraction
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [64:0] RND_HALF  = 65'h0_8000_0000;

  // exp(-2^(k-8)) in Q0.32, rounded to nearest
  localparam logic [31:0] EXP_ROM [NUM_ROM] = '{
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  typedef struct packed {
    logic [31:0] beam_intensity;
    logic [23:0] cross_section;
    logic [23:0] mass_attenuation;
    logic [23:0] depth;
    logic        last_in_frame;
  } baa_in_t;

  typedef struct packed {
    logic [31:0] flux;
    logic [39:0] absorption;
    logic        frame_end;
  } baa_out_t;

  // travels alongside the accumulator through the exp stages
  typedef struct packed {
    logic [31:0] beam;
    logic [23:0] cs;
    logic        last;
    logic        sat;   // exponent at or past 16.0
    logic [19:0] x;     // exponent, Q4.16
    logic [31:0] p;     // polynomial factor for the low 8 bits of x
  } baa_ctx_t;

endpackage

`default_nettype wire

// ===== src/baa_front.sv =====
// Front stage: exponent x = (cross_section + mass_attenuation) * depth >> 16.
// Uses baa_pkg.
`default_nettype none

module baa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  baa_pkg::baa_in_t   in_i,
  output logic               valid_o,
  output baa_pkg::baa_ctx_t  ctx_o
);
  import baa_pkg::*;

  logic [24:0] sum;
  logic [48:0] prod;
  logic [32:0] x_full;
  logic        valid_q;
  baa_ctx_t    ctx_d, ctx_q;

  assign sum    = {1'b0, in_i.cross_section} + {1'b0, in_i.mass_attenuation};
  assign prod   = 49'(sum) * 49'(in_i.depth);
  assign x_full = prod[48:16];

  always_comb begin
    ctx_d      = '0;
    ctx_d.beam = in_i.beam_intensity;
    ctx_d.cs   = in_i.cross_section;
    ctx_d.last = in_i.last_in_frame;
    ctx_d.sat  = |x_full[32:20];
    ctx_d.x    = x_full[19:0];
    ctx_d.p    = '0;  // filled in after this register
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q <= ctx_d;
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;

endmodule

`default_nettype wire

// ===== src/baa_mul_stage.sv =====
// One exp(-x) stage: acc = (acc * coef + 2^31) >> 32 when apply is set.
// Uses baa_pkg.
`default_nettype none

module baa_mul_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [32:0]        acc_i,
  input  logic [31:0]        coef_i,
  input  logic               apply_i,
  input  baa_pkg::baa_ctx_t  ctx_i,
  output logic               valid_o,
  output logic [32:0]        acc_o,
  output baa_pkg::baa_ctx_t  ctx_o
);
  import baa_pkg::*;

  logic [64:0] prod;
  logic [64:0] rnd;
  logic [32:0] acc_d, acc_q;
  logic        valid_q;
  baa_ctx_t    ctx_q;

  assign prod  = 65'(acc_i) * 65'(coef_i);
  assign rnd   = prod + RND_HALF;
  assign acc_d = apply_i ? rnd[64:32] : acc_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ctx_q <= ctx_i;
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign ctx_o   = ctx_q;

endmodule

`default_nettype wire

// ===== src/baa_back.sv =====
// Output stages: flux = beam * factor >> 16, then absorption = cs * flux >> 16.
// Uses baa_pkg.
`default_nettype none

module baa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [32:0]        acc_i,
  input  baa_pkg::baa_ctx_t  ctx_i,
  output logic               valid_o,
  output baa_pkg::baa_out_t  res_o
);
  import baa_pkg::*;

  logic [16:0] factor;
  logic [48:0] flux_full;
  logic [31:0] flux_d, flux_q;
  logic [23:0] cs_q;
  logic        last_q;
  logic        valid_a_q, valid_b_q;
  logic [55:0] abs_full;
  baa_out_t    res_d, res_q;

  // factor in units of 2^-16, 0..65536
  assign factor    = ctx_i.sat ? 17'd0 : acc_i[32:16];
  assign flux_full = 49'(ctx_i.beam) * 49'(factor);
  assign flux_d    = flux_full[47:16];

  assign abs_full  = 56'(cs_q) * 56'(flux_q);

  always_comb begin
    res_d.flux       = flux_q;
    res_d.absorption = abs_full[55:16];
    res_d.frame_end  = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flux_q <= flux_d;
    cs_q   <= ctx_i.cs;
    last_q <= ctx_i.last;
    res_q  <= res_d;
  end

  assign valid_o = valid_b_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// ===== src/beam_attenuation_absorption_top.sv =====
// Beer-Lambert attenuation and resonant absorption, one grid point per beat.
// Throughput one beat per cycle.
// Most of the depth comes from the chain of 13 exp(-x) multiply stages (12 table bits and
// the low-bit polynomial), each one 33x32 multiply between registers.
// busy is never raised: the receiver cannot stall and the pipeline never waits.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data is not reset.
`default_nettype none

module beam_attenuation_absorption_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  baa_pkg::baa_in_t   in_i,
  output logic               res_valid_o,
  output baa_pkg::baa_out_t  res_o
);
  import baa_pkg::*;

  localparam int unsigned NUM_STAGES = NUM_ROM + 1;

  logic        front_valid;
  baa_ctx_t    front_ctx;
  baa_ctx_t    poly_ctx;
  logic [7:0]  d;
  logic [15:0] dd;
  logic [32:0] p_full;

  logic        vld [NUM_STAGES+1];
  logic [32:0] acc [NUM_STAGES+1];
  baa_ctx_t    ctx [NUM_STAGES+1];

  assign busy = 1'b0;

  baa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .in_i    (in_i),
    .valid_o (front_valid),
    .ctx_o   (front_ctx)
  );

  // p = 1 - d/65536 + (d/65536)^2/2 in Q0.32; only used when d is nonzero
  assign d      = front_ctx.x[FRAC_BITS-1:0];
  assign dd     = 16'(d) * 16'(d);
  assign p_full = ONE_Q32 - {9'b0, d, 16'b0} + {18'b0, dd[15:1]};

  always_comb begin
    poly_ctx   = front_ctx;
    poly_ctx.p = p_full[31:0];
  end
  assign ctx[0] = poly_ctx;
  assign vld[0] = front_valid;
  assign acc[0] = ONE_Q32;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_exp
    logic [31:0] coef;
    logic        apply;
    if (k < NUM_ROM) begin : g_rom
      assign coef  = EXP_ROM[k];
      assign apply = ctx[k].x[k+FRAC_BITS];
    end else begin : g_poly
      assign coef  = ctx[k].p;
      assign apply = |ctx[k].x[FRAC_BITS-1:0];
    end

    baa_mul_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .acc_i   (acc[k]),
      .coef_i  (coef),
      .apply_i (apply),
      .ctx_i   (ctx[k]),
      .valid_o (vld[k+1]),
      .acc_o   (acc[k+1]),
      .ctx_o   (ctx[k+1])
    );
  end

  baa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[NUM_STAGES]),
    .acc_i   (acc[NUM_STAGES]),
    .ctx_i   (ctx[NUM_STAGES]),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

`ifndef SYNTH
  // every accepted beat leaves after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY res_valid_o)
    else $error("beat lost in pipeline");

  // zero depth gives a factor of exactly 1.0
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.depth == 24'd0
    |-> ##LATENCY res_o.flux == $past(in_i.beam_intensity, LATENCY))
    else $error("flux differs from beam at zero depth");

  // no beam, no flux and no absorption
  a_zero_beam: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.beam_intensity == 32'd0
    |-> ##LATENCY (res_o.flux == 32'd0 && res_o.absorption == 40'd0))
    else $error("nonzero result for zero beam");

  // frame marker kept with its beat
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY res_o.frame_end == $past(in_i.last_in_frame, LATENCY))
    else $error("frame marker out of step");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for beam_attenuation_absorption_top: directed corner beats,
// then a random stream checked against a bit-exact exp(-x) attenuation predictor.
// Depends on baa_pkg (beat types, LATENCY) and the top-level block.
`timescale 1ns / 100ps

module testbench;
  import baa_pkg::*;

  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_BEATS = 1750;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Expected flux/absorption store and exp(-x) predictor
  class absorption_scoreboard;
    baa_out_t    expected_results[$];
    int unsigned mismatches;
    logic [31:0] exp_table[12];

    function new();
      // exp(-2^(k-8)) in Q0.32, nearest
      exp_table = '{
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
      };
      mismatches = 0;
    endfunction

    function baa_out_t attenuated_point(baa_in_t pt);
      logic [24:0] coeff_sum;
      logic [48:0] exponent_prod;
      logic [32:0] x;
      logic [95:0] wide;
      logic [63:0] acc;
      logic [63:0] poly;
      logic [63:0] d;
      logic [16:0] factor;
      logic [63:0] beam_scaled;
      logic [63:0] absorb_wide;
      baa_out_t    res;
      coeff_sum     = {1'b0, pt.cross_section} + {1'b0, pt.mass_attenuation};
      exponent_prod = coeff_sum * pt.depth;
      x             = exponent_prod[48:16];
      if (x >= 33'h10_0000) begin
        factor = '0;
      end else begin
        acc = 64'd1 << 32;
        for (int k = 0; k < 12; k++) begin
          if (x[k + 8]) begin
            wide = acc * exp_table[k] + (96'd1 << 31);
            acc  = wide[95:32];
          end
        end
        d = {56'd0, x[7:0]};
        if (d != 0) begin
          poly = (64'd1 << 32) - (d << 16) + ((d * d) >> 1);
          wide = acc * poly + (96'd1 << 31);
          acc  = wide[95:32];
        end
        factor = acc[32:16];
      end
      beam_scaled    = pt.beam_intensity * factor;
      res.flux       = beam_scaled[47:16];
      absorb_wide    = pt.cross_section * res.flux;
      res.absorption = absorb_wide[55:16];
      res.frame_end  = pt.last_in_frame;
      return res;
    endfunction

    function void note_grid_point(baa_in_t pt);
      expected_results.push_back(attenuated_point(pt));
    endfunction

    function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected 0x%0h actual 0x%0h", what, exp_v, act_v);
    endfunction

    function void check_result(baa_out_t got);
      baa_out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: flux 0x%0h absorption 0x%0h",
                   got.flux, got.absorption);
        return;
      end
      want = expected_results.pop_front();
      if (got.flux !== want.flux) report("flux", want.flux, got.flux);
      if (got.absorption !== want.absorption)
        report("absorption", want.absorption, got.absorption);
      if (got.frame_end !== want.frame_end)
        report("frame_end", want.frame_end, got.frame_end);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  baa_in_t  in_i;
  logic     res_valid_o;
  baa_out_t res_o;

  absorption_scoreboard sb = new();
  logic        busy_seen = 1'b0;
  logic        idle_on   = 1'b1;
  int unsigned stall_cycles = 0;

  always #1 clk_i = ~clk_i;

  beam_attenuation_absorption_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Inputs move only at rising edges, so mid-cycle samples are stable.
  always @(negedge clk_i) begin
    busy_seen = busy;
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) sb.check_result(res_o);
    if ((start === 1'b1 && busy === 1'b0) || res_valid_o === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic baa_in_t grid_point(logic [31:0] beam, logic [23:0] cs,
                                         logic [23:0] ma, logic [23:0] dep,
                                         logic last);
    baa_in_t pt;
    pt.beam_intensity   = beam;
    pt.cross_section    = cs;
    pt.mass_attenuation = ma;
    pt.depth            = dep;
    pt.last_in_frame    = last;
    return pt;
  endfunction

  function automatic logic [23:0] random_span(int unsigned max_w);
    logic [31:0] mask;
    mask = (32'd1 << $urandom_range(1, max_w)) - 32'd1;
    return 24'($urandom & mask);
  endfunction

  task automatic send_grid_point(input baa_in_t pt);
    while (idle_on && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= pt;
    do @(posedge clk_i); while (busy_seen);
    sb.note_grid_point(pt);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] beam;
    logic [23:0] cs;
    logic [23:0] ma;
    logic [23:0] dep;
    int unsigned mode;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    in_i   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero exponent, full-scale beams, saturation edge, deep cut-off
    send_grid_point(grid_point(32'h0, 24'h0, 24'h0, 24'h0, 1'b0));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'hFF_FFFF, 24'h0, 24'h0, 1'b1));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'h08_0000, 24'h08_0000, 24'h01_0000, 1'b0));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'h0F_FFFF, 24'h0, 24'h01_0000, 1'b0));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'h0B_1720, 24'h0, 24'h01_0000, 1'b1));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'h0B_0000, 24'h0, 24'h01_0000, 1'b0));
    // one table bit at a time
    for (int k = 0; k < 12; k++)
      send_grid_point(grid_point(32'hFFFF_FFFF, 24'(32'd1 << (k + 8)), 24'h0,
                                 24'h01_0000, 1'(k % 2)));
    // polynomial only, cross section zero, exponent truncated to zero
    send_grid_point(grid_point(32'h8000_0001, 24'h0, 24'h1, 24'h01_0000, 1'b0));
    send_grid_point(grid_point(32'hFFFF_FFFF, 24'h7F, 24'h80, 24'h01_0000, 1'b1));
    send_grid_point(grid_point(32'h1234_5678, 24'h1, 24'h0, 24'h00_FFFF, 1'b0));

    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      idle_on = !(n >= 400 && n < 700);
      if (n == 900) drain_results();
      mode = $urandom_range(0, 9);
      case ($urandom_range(0, 7))
        0:       beam = 32'hFFFF_FFFF;
        1:       beam = $urandom_range(0, 255);
        default: beam = $urandom;
      endcase
      if (mode < 2) begin
        // unit depth: exponent follows the coefficient sum directly
        cs  = random_span(20);
        ma  = random_span(20);
        dep = 24'h01_0000;
      end else if (mode < 8) begin
        cs  = random_span(24);
        ma  = random_span(24);
        dep = random_span(24);
      end else begin
        cs  = 24'($urandom);
        ma  = 24'($urandom);
        dep = 24'($urandom);
      end
      send_grid_point(grid_point(beam, cs, ma, dep, 1'($urandom_range(0, 1))));
    end

    drain_results();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/baa_pkg.sv
src/baa_front.sv
src/baa_mul_stage.sv
src/baa_back.sv
src/beam_attenuation_absorption_top.sv
verif/testbench.sv
